/* hw/rtl/srt_pkg.sv */
// Shared types and constants for the sort block.
package srt_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;

  // One queued beat: a value to insert and/or the end-of-set marker.
  typedef struct packed {
    value_t value;
    logic   has_value;
    logic   last;
    logic   drop;
  } entry_t;

endpackage

/* hw/rtl/srt_ifs.sv */
// Handshake channels of the sort block.
interface srt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic               final_item;
  modport source (output valid, output sample_value, output final_item, input ready);
  modport sink   (input valid, input sample_value, input final_item, output ready);
endinterface

interface srt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sorted_value;
  logic               final_result;
  logic               overflowed;
  modport source (output valid, output sorted_value, output final_result,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input final_result,
                  input overflowed, output ready);
endinterface

interface srt_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/srt_front.sv */
// Input stage: counts the set, drops beats past capacity, feeds the queue.
module srt_front (
  input  logic            clk,
  input  logic            rst,
  srt_in_if.sink          samples,
  output logic            q_push,
  output srt_pkg::entry_t q_entry,
  input  logic            q_full
);
  import srt_pkg::*;

  count_t count;
  logic   drop;
  logic   accept;
  logic   room;

  assign samples.ready = !q_full;
  assign accept        = samples.valid && !q_full;
  assign room          = count < count_t'(MAX_ITEMS);

  assign q_push            = accept && (room || samples.final_item);
  assign q_entry.value     = samples.sample_value;
  assign q_entry.has_value = room;
  assign q_entry.last      = samples.final_item;
  assign q_entry.drop      = drop || !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      drop  <= 1'b0;
    end else if (accept) begin
      if (samples.final_item) begin
        count <= '0;
        drop  <= 1'b0;
      end else if (room) begin
        count <= count + count_t'(1);
      end else begin
        drop <= 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/srt_queue.sv */
// Short FIFO between the input stage and the sorter.
module srt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  srt_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output srt_pkg::entry_t head,
  output logic            not_empty
);
  import srt_pkg::*;

  entry_t                mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QCOUNT_W-1:0]   fill;
  logic                  do_push;
  logic                  do_pop;

  assign full      = fill == QCOUNT_W'(QUEUE_DEPTH);
  assign not_empty = fill != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCOUNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCOUNT_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/srt_back.sv */
// Insertion chain: keeps the set sorted while loading, then shifts it out.
module srt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            descending,
  input  logic            q_valid,
  input  srt_pkg::entry_t q_head,
  output logic            q_pop,
  srt_out_if.source       results
);
  import srt_pkg::*;

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic   state;
  count_t n;
  logic   drop;
  value_t cells      [MAX_ITEMS];
  value_t cells_next [MAX_ITEMS];
  logic   after_x    [MAX_ITEMS];
  logic   insert;
  logic   take;

  logic   out_valid;
  value_t out_value;
  logic   out_last;
  logic   out_drop;

  // true when a belongs after b in the selected order
  function automatic logic belongs_after(value_t a, value_t b, logic desc);
    return desc ? (a < b) : (a > b);
  endfunction

  assign q_pop  = (state == ST_LOAD) && q_valid;
  assign insert = q_pop && q_head.has_value;
  assign take   = (state == ST_DRAIN) && (!out_valid || results.ready);

  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      after_x[i] = (COUNT_W'(i) >= n) || belongs_after(cells[i], q_head.value, descending);
    end
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (!after_x[i]) begin
        cells_next[i] = cells[i];
      end else if (i > 0 && after_x[(i > 0) ? i - 1 : 0]) begin
        cells_next[i] = cells[(i > 0) ? i - 1 : 0];
      end else begin
        cells_next[i] = q_head.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
        cells[i] <= cells_next[i];
      end
    end else if (take) begin
      for (int i = 0; i < MAX_ITEMS - 1; i++) begin
        cells[i] <= cells[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      n     <= '0;
      drop  <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (q_pop) begin
            if (q_head.has_value) begin
              n <= n + count_t'(1);
            end
            if (q_head.last) begin
              drop  <= q_head.drop;
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (take) begin
            n <= n - count_t'(1);
            if (n == count_t'(1)) begin
              state <= ST_LOAD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_value <= cells[0];
      out_last  <= n == count_t'(1);
      out_drop  <= drop;
    end
  end

  assign results.valid        = out_valid;
  assign results.sorted_value = out_value;
  assign results.final_result = out_last;
  assign results.overflowed   = out_drop;

endmodule

/* hw/rtl/sort_ascending_or_descending.sv */
// Sort block top: order register, input stage, queue and insertion chain.
// Loading: one beat per cycle while the queue has room; each value is written into the queue,
// then inserted into the chain when the load state pops it. After the final beat the chain
// drains, one result per cycle while the sink is ready; input stalls once the queue fills
// during the drain.
// Reset (synchronous, active high) clears counts, queue, chain state and the order bit.
module sort_ascending_or_descending (
  input  logic      clk,
  input  logic      rst,
  srt_in_if.sink    samples,
  srt_out_if.source results,
  srt_cfg_if.sink   cfg
);
  import srt_pkg::*;

  logic   descending;
  logic   q_push;
  entry_t q_in;
  logic   q_full;
  logic   q_pop;
  entry_t q_head;
  logic   q_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg.valid) begin
      descending <= cfg.data;
    end
  end

  srt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .q_push  (q_push),
    .q_entry (q_in),
    .q_full  (q_full)
  );

  srt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .not_empty  (q_valid)
  );

  srt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .descending (descending),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .results    (results)
  );

endmodule
